FILE: src/rmj_pkg.sv
package rmj_pkg;

   // default number format, signed Q16.16
   localparam int unsigned DataWidthDef = 32;
   localparam int unsigned FracBitsDef  = 16;

endpackage

FILE: src/rmj_if.sv
interface rmj_req_if #(
   parameter int unsigned DATA_WIDTH = rmj_pkg::DataWidthDef
) ();
   import rmj_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] pos_x;
   logic signed [DATA_WIDTH-1:0] pos_y;
   logic signed [DATA_WIDTH-1:0] vel_x;
   logic signed [DATA_WIDTH-1:0] vel_y;

   modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
   modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface rmj_rsp_if #(
   parameter int unsigned DATA_WIDTH = rmj_pkg::DataWidthDef
) ();
   import rmj_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] drange_dpx;
   logic signed [DATA_WIDTH-1:0] drange_dpy;
   logic signed [DATA_WIDTH-1:0] dbearing_dpx;
   logic signed [DATA_WIDTH-1:0] dbearing_dpy;
   logic signed [DATA_WIDTH-1:0] drate_dpx;
   logic signed [DATA_WIDTH-1:0] drate_dpy;
   logic                         zero_range_error;

   modport source (output valid, drange_dpx, drange_dpy, dbearing_dpx, dbearing_dpy,
                   drate_dpx, drate_dpy, zero_range_error, input ready);
   modport sink (input valid, drange_dpx, drange_dpy, dbearing_dpx, dbearing_dpy,
                 drate_dpx, drate_dpy, zero_range_error, output ready);
endinterface

FILE: src/radar_measurement_jacobian.sv
// radar measurement jacobian, one state vector in, six jacobian entries out
//
// req carries pos_x, pos_y, vel_x, vel_y (signed, FRAC_BITS fraction bits);
// rsp carries the six distinct entries of the 3x4 radar jacobian, saturated,
// plus zero_range_error, which is set (and all entries zero) when pos_x and
// pos_y are both zero. both channels transfer on valid and ready high.
//
// the datapath is a stall-all pipeline of 2*DATA_WIDTH+7 register stages
// (71 at the default width): unpack, four products, sums, a one-bit-per-stage
// square root (DATA_WIDTH stages), two stages of split products for the
// cubed range, then six restoring dividers of DATA_WIDTH+1 stages each and
// a saturating output register. a transfer in can happen every cycle while
// no result waits on rsp with rsp.ready low.
//
// when rsp.ready is low with a result waiting, the whole pipeline holds and
// req.ready drops; nothing is lost or repeated. reset clears only the valid
// bits, the data registers keep whatever they hold.
module radar_measurement_jacobian #(
   parameter int unsigned DATA_WIDTH = rmj_pkg::DataWidthDef,
   parameter int unsigned FRAC_BITS  = rmj_pkg::FracBitsDef
) (
   input logic       clock,
   input logic       reset,
   rmj_req_if.sink   req,
   rmj_rsp_if.source rsp
);
   import rmj_pkg::*;

   localparam int unsigned W   = DATA_WIDTH;
   localparam int unsigned F   = FRAC_BITS;
   localparam int unsigned NST = 2 * W + 7;

   localparam logic [W-1:0] MaxPos = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0] MinNeg = {1'b1, {(W - 1){1'b0}}};

   // payload riding alongside the square root
   typedef struct packed {
      logic [2*W-1:0] r2;
      logic [2*W-1:0] c;
      logic [W-1:0]   mp;
      logic [W-1:0]   mq;
      logic           sc;
      logic           sp;
      logic           sq;
      logic           zero;
   } side_type;

   // sign of each entry plus the zero flag, alongside the dividers
   typedef struct packed {
      logic       zero;
      logic [5:0] neg;
   } flag_type;

   function automatic logic [W-1:0] sat_pack(input logic [W-1:0] q, input logic ovf,
                                             input logic neg);
      logic big_q;
      big_q = ovf || (q[W-1] && (q[W-2:0] != '0));
      if (neg) begin
         sat_pack = big_q ? MinNeg : W'(~q + 1'b1);
      end else begin
         sat_pack = (ovf || q[W-1]) ? MaxPos : q;
      end
   endfunction

   // pipeline advance and valid bits
   logic           adv;
   logic [NST-1:0] vld_ff;

   assign adv       = !vld_ff[NST-1] || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req.valid};
      end
   end

   // stage 0: magnitudes and signs
   logic [W-1:0] mp_s0_ff, mq_s0_ff, mvx_s0_ff, mvy_s0_ff;
   logic         sp_s0_ff, sq_s0_ff, svx_s0_ff, svy_s0_ff, zero_s0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mp_s0_ff   <= req.pos_x[W-1] ? W'(~req.pos_x + 1'b1) : req.pos_x;
         mq_s0_ff   <= req.pos_y[W-1] ? W'(~req.pos_y + 1'b1) : req.pos_y;
         mvx_s0_ff  <= req.vel_x[W-1] ? W'(~req.vel_x + 1'b1) : req.vel_x;
         mvy_s0_ff  <= req.vel_y[W-1] ? W'(~req.vel_y + 1'b1) : req.vel_y;
         sp_s0_ff   <= req.pos_x[W-1];
         sq_s0_ff   <= req.pos_y[W-1];
         svx_s0_ff  <= req.vel_x[W-1];
         svy_s0_ff  <= req.vel_y[W-1];
         zero_s0_ff <= (req.pos_x == '0) && (req.pos_y == '0);
      end
   end

   // stage 1: squares and cross products, signs of vx*q and -vy*p
   logic [2*W-1:0] pp_s1_ff, qq_s1_ff, a_s1_ff, b_s1_ff;
   logic [W-1:0]   mp_s1_ff, mq_s1_ff;
   logic           sa_s1_ff, sb_s1_ff, sp_s1_ff, sq_s1_ff, zero_s1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_s1_ff   <= mp_s0_ff * mp_s0_ff;
         qq_s1_ff   <= mq_s0_ff * mq_s0_ff;
         a_s1_ff    <= mvx_s0_ff * mq_s0_ff;
         b_s1_ff    <= mvy_s0_ff * mp_s0_ff;
         sa_s1_ff   <= svx_s0_ff ^ sq_s0_ff;
         sb_s1_ff   <= !(svy_s0_ff ^ sp_s0_ff);
         mp_s1_ff   <= mp_s0_ff;
         mq_s1_ff   <= mq_s0_ff;
         sp_s1_ff   <= sp_s0_ff;
         sq_s1_ff   <= sq_s0_ff;
         zero_s1_ff <= zero_s0_ff;
      end
   end

   // stage 2: squared range and c = vx*q - vy*p in sign and magnitude
   side_type s2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff.r2 <= pp_s1_ff + qq_s1_ff;
         priority if (sa_s1_ff == sb_s1_ff) begin
            s2_ff.c  <= a_s1_ff + b_s1_ff;
            s2_ff.sc <= sa_s1_ff;
         end else if (a_s1_ff >= b_s1_ff) begin
            s2_ff.c  <= a_s1_ff - b_s1_ff;
            s2_ff.sc <= sa_s1_ff;
         end else begin
            s2_ff.c  <= b_s1_ff - a_s1_ff;
            s2_ff.sc <= sb_s1_ff;
         end
         s2_ff.mp   <= mp_s1_ff;
         s2_ff.mq   <= mq_s1_ff;
         s2_ff.sp   <= sp_s1_ff;
         s2_ff.sq   <= sq_s1_ff;
         s2_ff.zero <= zero_s1_ff;
      end
   end

   // range, rounded down
   logic [W-1:0] rng;
   side_type     sq_out;

   rmj_sqrt #(
      .W      (W),
      .SIDE_W ($bits(side_type))
   ) u_sqrt (
      .clock    (clock),
      .en       (adv),
      .rad      (s2_ff.r2),
      .side_in  (s2_ff),
      .root     (rng),
      .side_out (sq_out)
   );

   // m1: half products of r2*rng, q*c and p*c
   logic [2*W-1:0] dl_m1_ff, dh_m1_ff, ql_m1_ff, qh_m1_ff, pl_m1_ff, ph_m1_ff;
   logic [W-1:0]   rng_m1_ff;
   side_type       m1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dl_m1_ff  <= sq_out.r2[W-1:0] * rng;
         dh_m1_ff  <= sq_out.r2[2*W-1:W] * rng;
         ql_m1_ff  <= sq_out.mq * sq_out.c[W-1:0];
         qh_m1_ff  <= sq_out.mq * sq_out.c[2*W-1:W];
         pl_m1_ff  <= sq_out.mp * sq_out.c[W-1:0];
         ph_m1_ff  <= sq_out.mp * sq_out.c[2*W-1:W];
         rng_m1_ff <= rng;
         m1_ff     <= sq_out;
      end
   end

   // m2: combine halves, fix the sign of each entry
   logic [3*W-1:0] den3_m2_ff, qc_m2_ff, pc_m2_ff;
   logic [2*W-1:0] r2_m2_ff;
   logic [W-1:0]   rng_m2_ff, mp_m2_ff, mq_m2_ff;
   flag_type       fl_m2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         den3_m2_ff    <= (3 * W)'(dl_m1_ff) + {dh_m1_ff, {W{1'b0}}};
         qc_m2_ff      <= (3 * W)'(ql_m1_ff) + {qh_m1_ff, {W{1'b0}}};
         pc_m2_ff      <= (3 * W)'(pl_m1_ff) + {ph_m1_ff, {W{1'b0}}};
         r2_m2_ff      <= m1_ff.r2;
         rng_m2_ff     <= rng_m1_ff;
         mp_m2_ff      <= m1_ff.mp;
         mq_m2_ff      <= m1_ff.mq;
         fl_m2_ff.zero <= m1_ff.zero;
         fl_m2_ff.neg  <= {m1_ff.sp == m1_ff.sc, m1_ff.sq != m1_ff.sc,
                           m1_ff.sp, !m1_ff.sq, m1_ff.sq, m1_ff.sp};
      end
   end

   // dividers, all in lockstep
   logic [W-1:0] quo [6];
   logic         ovf [6];

   rmj_div #(.W(W), .NW(W + F), .DW(W)) u_div_rpx (
      .clock (clock), .en (adv), .num ({mp_m2_ff, {F{1'b0}}}), .den (rng_m2_ff),
      .quo (quo[0]), .ovf (ovf[0])
   );

   rmj_div #(.W(W), .NW(W + F), .DW(W)) u_div_rpy (
      .clock (clock), .en (adv), .num ({mq_m2_ff, {F{1'b0}}}), .den (rng_m2_ff),
      .quo (quo[1]), .ovf (ovf[1])
   );

   rmj_div #(.W(W), .NW(W + 2 * F), .DW(2 * W)) u_div_bpx (
      .clock (clock), .en (adv), .num ({mq_m2_ff, {(2 * F){1'b0}}}), .den (r2_m2_ff),
      .quo (quo[2]), .ovf (ovf[2])
   );

   rmj_div #(.W(W), .NW(W + 2 * F), .DW(2 * W)) u_div_bpy (
      .clock (clock), .en (adv), .num ({mp_m2_ff, {(2 * F){1'b0}}}), .den (r2_m2_ff),
      .quo (quo[3]), .ovf (ovf[3])
   );

   rmj_div #(.W(W), .NW(3 * W + F), .DW(3 * W)) u_div_dpx (
      .clock (clock), .en (adv), .num ({qc_m2_ff, {F{1'b0}}}), .den (den3_m2_ff),
      .quo (quo[4]), .ovf (ovf[4])
   );

   rmj_div #(.W(W), .NW(3 * W + F), .DW(3 * W)) u_div_dpy (
      .clock (clock), .en (adv), .num ({pc_m2_ff, {F{1'b0}}}), .den (den3_m2_ff),
      .quo (quo[5]), .ovf (ovf[5])
   );

   // signs and zero flag delayed to match the dividers
   flag_type fl_ff [W+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         fl_ff[0] <= fl_m2_ff;
         for (int k = 1; k <= W; k++) begin
            fl_ff[k] <= fl_ff[k-1];
         end
      end
   end

   // output register: saturate, force zeros on zero range
   logic [W-1:0] ent_ff [6];
   logic         err_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 6; k++) begin
            ent_ff[k] <= fl_ff[W].zero ? '0 : sat_pack(quo[k], ovf[k], fl_ff[W].neg[k]);
         end
         err_ff <= fl_ff[W].zero;
      end
   end

   assign rsp.drange_dpx       = ent_ff[0];
   assign rsp.drange_dpy       = ent_ff[1];
   assign rsp.dbearing_dpx     = ent_ff[2];
   assign rsp.dbearing_dpy     = ent_ff[3];
   assign rsp.drate_dpx        = ent_ff[4];
   assign rsp.drate_dpy        = ent_ff[5];
   assign rsp.zero_range_error = err_ff;

`ifndef ASSERT_OFF
   // a flagged result carries all-zero entries
   a_zero_entries : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.zero_range_error |->
         rsp.drange_dpx == '0 && rsp.drange_dpy == '0 && rsp.dbearing_dpx == '0 &&
         rsp.dbearing_dpy == '0 && rsp.drate_dpx == '0 && rsp.drate_dpy == '0)
      else $error("zero range result with nonzero entries");

   // a waiting result freezes the pipeline and blocks the input
   a_stall_freeze : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("input open while output stalled");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp.valid)
      else $error("result valid right after reset");
`endif

endmodule

FILE: src/rmj_sqrt.sv
module rmj_sqrt #(
   parameter int unsigned W      = rmj_pkg::DataWidthDef,
   parameter int unsigned SIDE_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [2*W-1:0]    rad,
   input  logic [SIDE_W-1:0] side_in,
   output logic [W-1:0]      root,
   output logic [SIDE_W-1:0] side_out
);
   import rmj_pkg::*;

   // one root bit per stage, two radicand bits consumed per stage
   logic [W+1:0]     rem_ff  [W];
   logic [W-1:0]     root_ff [W];
   logic [2*W-1:0]   rad_ff  [W];
   logic [SIDE_W-1:0] side_ff [W];

   for (genvar i = 0; i < W; i++) begin : g_step
      logic [W+1:0]      rem_p;
      logic [W-1:0]      root_p;
      logic [2*W-1:0]    rad_p;
      logic [SIDE_W-1:0] side_p;
      logic [W+1:0]      cur;
      logic [W+2:0]      dif;

      if (i == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = rad;
         assign side_p = side_in;
      end else begin : g_next
         assign rem_p  = rem_ff[i-1];
         assign root_p = root_ff[i-1];
         assign rad_p  = rad_ff[i-1];
         assign side_p = side_ff[i-1];
      end

      assign cur = {rem_p[W-1:0], rad_p[2*W-1 -: 2]};
      assign dif = {1'b0, cur} - {1'b0, root_p, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            if (!dif[W+2]) begin
               rem_ff[i]  <= dif[W+1:0];
               root_ff[i] <= {root_p[W-2:0], 1'b1};
            end else begin
               rem_ff[i]  <= cur;
               root_ff[i] <= {root_p[W-2:0], 1'b0};
            end
            rad_ff[i]  <= {rad_p[2*W-3:0], 2'b00};
            side_ff[i] <= side_p;
         end
      end
   end

   assign root     = root_ff[W-1];
   assign side_out = side_ff[W-1];

endmodule

FILE: src/rmj_div.sv
module rmj_div #(
   parameter int unsigned W  = rmj_pkg::DataWidthDef,
   parameter int unsigned NW = 2 * rmj_pkg::DataWidthDef,
   parameter int unsigned DW = rmj_pkg::DataWidthDef
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [W-1:0]  quo,
   output logic          ovf
);
   import rmj_pkg::*;

   // upper numerator bits, compared at the wider of their width and the divisor's
   localparam int unsigned HW = NW - W;
   localparam int unsigned EW = (HW > DW) ? HW : DW;

   logic [EW-1:0] hi_full;
   logic [DW-1:0] hi_ext;
   logic          hi_ovf;

   logic [DW-1:0] rem0_ff;
   logic [W-1:0]  lo0_ff;
   logic [DW-1:0] den0_ff;
   logic          ovf0_ff;

   logic [DW-1:0] rem_ff [W];
   logic [W-1:0]  lo_ff  [W];
   logic [DW-1:0] den_ff [W];
   logic [W-1:0]  quo_ff [W];
   logic          ovf_ff [W];

   assign hi_full = EW'(num[NW-1:W]);
   assign hi_ovf  = (hi_full >= EW'(den));
   assign hi_ext  = DW'(hi_full);

   // a quotient of more than W bits is flagged as overflow and saturates anyway
   always_ff @(posedge clock) begin
      if (en) begin
         rem0_ff <= hi_ovf ? '0 : hi_ext;
         lo0_ff  <= num[W-1:0];
         den0_ff <= den;
         ovf0_ff <= hi_ovf;
      end
   end

   for (genvar j = 0; j < W; j++) begin : g_step
      logic [DW-1:0] rem_p;
      logic [W-1:0]  lo_p;
      logic [DW-1:0] den_p;
      logic [W-1:0]  quo_p;
      logic          ovf_p;
      logic [DW:0]   cur;
      logic [DW:0]   dif;

      if (j == 0) begin : g_first
         assign rem_p = rem0_ff;
         assign lo_p  = lo0_ff;
         assign den_p = den0_ff;
         assign quo_p = '0;
         assign ovf_p = ovf0_ff;
      end else begin : g_next
         assign rem_p = rem_ff[j-1];
         assign lo_p  = lo_ff[j-1];
         assign den_p = den_ff[j-1];
         assign quo_p = quo_ff[j-1];
         assign ovf_p = ovf_ff[j-1];
      end

      assign cur = {rem_p, lo_p[W-1]};
      assign dif = cur - {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (en) begin
            if (!dif[DW] || cur[DW]) begin
               rem_ff[j] <= dif[DW-1:0];
               quo_ff[j] <= {quo_p[W-2:0], 1'b1};
            end else begin
               rem_ff[j] <= cur[DW-1:0];
               quo_ff[j] <= {quo_p[W-2:0], 1'b0};
            end
            lo_ff[j]  <= {lo_p[W-2:0], 1'b0};
            den_ff[j] <= den_p;
            ovf_ff[j] <= ovf_p;
         end
      end
   end

   assign quo = quo_ff[W-1];
   assign ovf = ovf_ff[W-1];

endmodule

FILE: verif/tb.sv
module tb;
   import rmj_pkg::*;

   localparam int unsigned DW = DataWidthDef;
   localparam int unsigned FB = FracBitsDef;
   localparam int unsigned LATENCY = 2 * DW + 7;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned N_RANDOM = 1330;

   typedef logic [255:0] wide_type;
   typedef logic signed [DW-1:0] word_type;

   typedef struct packed {
      word_type pos_x;
      word_type pos_y;
      word_type vel_x;
      word_type vel_y;
   } state_vec_type;

   // one pending transfer; hold_off makes the sender wait for an empty pipe first
   typedef struct packed {
      state_vec_type sv;
      bit            hold_off;
   } pending_type;

   typedef struct packed {
      word_type drange_dpx;
      word_type drange_dpy;
      word_type dbearing_dpx;
      word_type dbearing_dpy;
      word_type drate_dpx;
      word_type drate_dpy;
      logic     zero_range_error;
   } jacobian_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmj_req_if #(.DATA_WIDTH(DW)) req_ch ();
   rmj_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   radar_measurement_jacobian #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #6 clock = ~clock;

   pending_type  state_queue[$];
   jacobian_type jacobian_queue[$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   bit          stimulus_done = 1'b0;

   // ---------------------------------------------------------------
   // jacobian predictor, exact integer math on wide vectors
   // ---------------------------------------------------------------

   // magnitude of a raw field; the most negative value maps to 2^(DW-1)
   function automatic wide_type magnitude(word_type v);
      logic [DW-1:0] m;
      m = v[DW-1] ? (~v + 1'b1) : v;
      return wide_type'(m);
   endfunction

   // truncated magnitude and sign to a saturated signed word
   function automatic word_type saturate(wide_type m, bit neg);
      wide_type half;
      half = wide_type'(1) << (DW - 1);
      if (neg) begin
         if (m > half) return word_type'(half);
         return word_type'(-m);
      end
      if (m > half - 1) return word_type'(half - 1);
      return word_type'(m);
   endfunction

   function automatic wide_type floor_sqrt(wide_type n);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (wide_type'(t) * wide_type'(t) <= n) r = t;
      end
      return wide_type'(r);
   endfunction

   function automatic jacobian_type radar_jacobian(state_vec_type s);
      jacobian_type j;
      wide_type mp, mq, mvx, mvy, r2, rng, den3, a, b, c;
      bit sp, sq, sa, sb, sc;
      mp  = magnitude(s.pos_x);
      mq  = magnitude(s.pos_y);
      mvx = magnitude(s.vel_x);
      mvy = magnitude(s.vel_y);
      sp  = s.pos_x[DW-1];
      sq  = s.pos_y[DW-1];
      j   = '0;
      if (mp == 0 && mq == 0) begin
         // target at the sensor: range undefined, all entries zero
         j.zero_range_error = 1'b1;
         return j;
      end
      r2   = mp * mp + mq * mq;
      rng  = floor_sqrt(r2);
      den3 = r2 * rng;
      // cross term vx*py - vy*px kept as sign and magnitude
      a  = mvx * mq;
      sa = s.vel_x[DW-1] ^ sq;
      b  = mvy * mp;
      sb = !(s.vel_y[DW-1] ^ sp);
      if (sa == sb) begin
         c = a + b; sc = sa;
      end else if (a >= b) begin
         c = a - b; sc = sa;
      end else begin
         c = b - a; sc = sb;
      end
      j.drange_dpx   = saturate((mp << FB) / rng, sp);
      j.drange_dpy   = saturate((mq << FB) / rng, sq);
      j.dbearing_dpx = saturate((mq << (2 * FB)) / r2, !sq);
      j.dbearing_dpy = saturate((mp << (2 * FB)) / r2, sp);
      j.drate_dpx    = saturate(((mq * c) << FB) / den3, sq != sc);
      j.drate_dpy    = saturate(((mp * c) << FB) / den3, sp == sc);
      return j;
   endfunction

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   function automatic word_type rand_word();
      return word_type'($urandom);
   endfunction

   // values of random magnitude, mostly moderate so results stay unsaturated
   function automatic word_type rand_scaled();
      word_type v;
      v = rand_word() >>> $urandom_range(DW - 1, 0);
      return v;
   endfunction

   task automatic add_state(word_type px, word_type py, word_type vx, word_type vy,
                            bit hold);
      pending_type p;
      p.sv.pos_x = px;
      p.sv.pos_y = py;
      p.sv.vel_x = vx;
      p.sv.vel_y = vy;
      p.hold_off = hold;
      state_queue.push_back(p);
   endtask

   initial begin
      word_type mx, mn, one;
      int unsigned kind;
      bit hold;
      mx  = {1'b0, {(DW-1){1'b1}}};
      mn  = {1'b1, {(DW-1){1'b0}}};
      one = word_type'(1) << FB;

      // zero range, with and without velocity
      add_state('0, '0, '0, '0, 1'b0);
      add_state('0, '0, mx, mn, 1'b0);
      // one unit on each axis
      add_state(one, '0, one, '0, 1'b0);
      add_state('0, one, '0, one, 1'b0);
      add_state(-one, '0, '0, -one, 1'b0);
      add_state('0, -one, one, one, 1'b0);
      // tiny range, bearing entries saturate
      add_state(word_type'(1), '0, '0, '0, 1'b0);
      add_state('0, word_type'(-1), mx, mx, 1'b0);
      add_state(word_type'(1), word_type'(1), mn, mx, 1'b0);
      // field extremes, most negative taken at its exact value
      add_state(mx, mx, mx, mx, 1'b0);
      add_state(mn, mn, mn, mn, 1'b0);
      add_state(mn, mx, mx, mn, 1'b0);
      add_state(mx, mn, mn, mx, 1'b0);
      add_state(mn, '0, mx, mx, 1'b0);
      add_state('0, mn, mn, mn, 1'b0);
      // large velocity with small position: rate entries saturate; then mixed cases
      add_state(word_type'(3), word_type'(-5), mx, mn, 1'b0);
      add_state(one, one, one, -one, 1'b0);
      add_state(3 * one, 4 * one, -2 * one, 7 * one, 1'b0);
      add_state(word_type'(-1), word_type'(-1), word_type'(-1), word_type'(-1), 1'b0);

      for (int i = 0; i < N_RANDOM; i++) begin
         kind = $urandom_range(9, 0);
         hold = ((i % 300) == 150);
         case (kind)
            0: begin
               add_state(rand_word(), rand_word(), rand_word(), rand_word(), hold);
            end
            1: begin
               add_state('0, '0, rand_word(), rand_word(), hold);
            end
            2: begin
               // one position axis at zero
               if ($urandom_range(1, 0))
                  add_state('0, rand_scaled(), rand_scaled(), rand_scaled(), hold);
               else
                  add_state(rand_scaled(), '0, rand_scaled(), rand_scaled(), hold);
            end
            default: begin
               add_state(rand_scaled(), rand_scaled(), rand_scaled(), rand_scaled(),
                         hold);
            end
         endcase
      end
      stimulus_done = 1'b1;
   end

   // ---------------------------------------------------------------
   // reset and sender
   // ---------------------------------------------------------------

   initial begin
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.vel_x = '0;
      req_ch.vel_y = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
   end

   bit          req_fired = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(negedge clock) begin
      if (!reset) begin
         // current item stays on the bus until its transfer
         if (!req_ch.valid || req_fired) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(40, 1);
               // some bursts run back to back, others after a gap
               gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            end
            if (gap_left != 0 && burst_left == 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (state_queue.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (state_queue[0].hold_off && jacobian_queue.size() != 0) begin
               // drain the pipeline before this one goes in
               req_ch.valid <= 1'b0;
            end else begin
               if (burst_left != 0) burst_left--;
               req_ch.valid <= 1'b1;
               req_ch.pos_x <= state_queue[0].sv.pos_x;
               req_ch.pos_y <= state_queue[0].sv.pos_y;
               req_ch.vel_x <= state_queue[0].sv.vel_x;
               req_ch.vel_y <= state_queue[0].sv.vel_y;
               void'(state_queue.pop_front());
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver stall pattern: phases of always-ready, coin toss and mostly stalled
   // ---------------------------------------------------------------

   int unsigned stall_phase = 0;
   int unsigned phase_left = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (phase_left == 0) begin
            stall_phase = $urandom_range(2, 0);
            phase_left  = $urandom_range(200, 20);
         end
         phase_left--;
         case (stall_phase)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(1, 0));
            default: rsp_ch.ready <= ($urandom_range(7, 0) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // monitor and checking at the rising edge
   // ---------------------------------------------------------------

   task automatic report(string what, word_type got, word_type want);
      mismatches++;
      $display("tb: mismatch %s got %h expected %h at cycle %0d", what, got, want,
               cycle_count);
   endtask

   always @(posedge clock) begin
      state_vec_type s;
      jacobian_type  e;
      cycle_count++;
      req_fired <= req_ch.valid && req_ch.ready && !reset;
      if (!reset && req_ch.valid && req_ch.ready) begin
         s.pos_x = req_ch.pos_x;
         s.pos_y = req_ch.pos_y;
         s.vel_x = req_ch.vel_x;
         s.vel_y = req_ch.vel_y;
         jacobian_queue.push_back(radar_jacobian(s));
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (jacobian_queue.size() == 0) begin
            report("unexpected transfer", rsp_ch.drange_dpx, '0);
         end else begin
            e = jacobian_queue.pop_front();
            if (rsp_ch.drange_dpx !== e.drange_dpx)
               report("drange_dpx", rsp_ch.drange_dpx, e.drange_dpx);
            if (rsp_ch.drange_dpy !== e.drange_dpy)
               report("drange_dpy", rsp_ch.drange_dpy, e.drange_dpy);
            if (rsp_ch.dbearing_dpx !== e.dbearing_dpx)
               report("dbearing_dpx", rsp_ch.dbearing_dpx, e.dbearing_dpx);
            if (rsp_ch.dbearing_dpy !== e.dbearing_dpy)
               report("dbearing_dpy", rsp_ch.dbearing_dpy, e.dbearing_dpy);
            if (rsp_ch.drate_dpx !== e.drate_dpx)
               report("drate_dpx", rsp_ch.drate_dpx, e.drate_dpx);
            if (rsp_ch.drate_dpy !== e.drate_dpy)
               report("drate_dpy", rsp_ch.drate_dpy, e.drate_dpy);
            if (rsp_ch.zero_range_error !== e.zero_range_error)
               report("zero_range_error", word_type'(rsp_ch.zero_range_error),
                      word_type'(e.zero_range_error));
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // end of run
   // ---------------------------------------------------------------

   initial begin
      wait (stimulus_done);
      @(posedge clock);
      while (state_queue.size() != 0 || (req_ch.valid && !req_fired) ||
             jacobian_queue.size() != 0)
         @(posedge clock);
      // leftovers would show up as unexpected transfers here
      repeat (LATENCY + 50) @(posedge clock);
      if (mismatches == 0 && jacobian_queue.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/rmj_pkg.sv
src/rmj_if.sv
src/rmj_sqrt.sv
src/rmj_div.sv
src/radar_measurement_jacobian.sv
verif/tb.sv
